[hdl/alfl_pkg.sv]
// Package for the array linked list with free list: sizes, codes and types.
// Used by alfl_ram, alfl_ctrl and the top level; depends on nothing.
package alfl_pkg;
   localparam int NODES     = 256;
   localparam int DATA_BITS = 32;
   localparam int IDX_BITS  = $clog2(NODES + 1);
   localparam int ADR_BITS  = $clog2(NODES);
   localparam logic [IDX_BITS-1:0] NONE = IDX_BITS'(NODES);

   typedef enum logic [2:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_REAR  = 3'd1,
      OP_RM_FRONT  = 3'd2,
      OP_RM_REAR   = 3'd3,
      OP_RM_CUR    = 3'd4,
      OP_SEARCH    = 3'd5,
      OP_CLEAR     = 3'd6,
      OP_NOP       = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_WAIT,
      S_STEP,
      S_READCUR,
      S_LOAD,
      S_DONE
   } state_type;

   // One memory access from the controller to the node store.
   typedef struct packed {
      logic                 rd;
      logic [ADR_BITS-1:0]  rd_adr;
      logic                 wr_data;
      logic                 wr_link;
      logic                 wr_free;
      logic [ADR_BITS-1:0]  wr_adr;
      logic [DATA_BITS-1:0] data;
      logic [IDX_BITS-1:0]  link;
   } mem_req_type;

   typedef struct packed {
      logic [DATA_BITS-1:0] data;
      logic [IDX_BITS-1:0]  link;
      logic [IDX_BITS-1:0]  free;
   } mem_rsp_type;
endpackage

[hdl/array_linked_list_with_free_list.sv]
// Top level of the array linked list with free list.
// Depends on alfl_pkg, alfl_ram and alfl_ctrl.
//  channel | direction | fields (low bit up)
//  req     | in        | tdata: op[2:0], data_in[34:3]
//  rsp     | out       | tdata: status[1:0], found_index[10:2],
//          |           |        current_index[19:11], current_data[51:20]
//  csr     | in        | key_mask
// One request at a time: its cost grows with each node read, with a second write and
// with a free list pop, and a walk of the whole list is bound by the single read port;
// the block returns to idle before it takes the next request.
// Reset is synchronous; it empties the list with no clearing pass.
// A result waits in its register until taken; no new request enters meanwhile.
module array_linked_list_with_free_list (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // op, data_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // status, found_index, current_index, current_data
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);
   import alfl_pkg::*;

   logic [31:0] key_mask_ff;
   mem_req_type mreq;
   mem_rsp_type mrsp;
   logic idle, done;
   logic [1:0] status;
   logic [IDX_BITS-1:0] fidx, cidx;
   logic [DATA_BITS-1:0] cdata;

   always_ff @(posedge clock) begin
      if (reset) key_mask_ff <= '1;
      else if (csr_we) key_mask_ff <= csr_wdata;
   end

   assign req_tready = idle;
   assign rsp_tvalid = done;
   assign rsp_tdata = {4'd0, cdata, cidx, fidx, status};

   alfl_ram u_ram (.clock, .mreq, .mrsp);

   alfl_ctrl u_ctrl (
      .clock, .reset,
      .start(req_tvalid && req_tready),
      .op(op_type'(req_tdata[2:0])),
      .din(req_tdata[34:3]),
      .key_mask(key_mask_ff),
      .idle, .done, .taken(rsp_tready),
      .status, .found_index(fidx), .current_index(cidx), .current_data(cdata),
      .mreq, .mrsp
   );
endmodule

[hdl/alfl_ram.sv]
// Node store: data, link and free link arrays with registered reads.
// Depends on alfl_pkg.
module alfl_ram (
   input  logic                 clock,
   input  alfl_pkg::mem_req_type mreq,
   output alfl_pkg::mem_rsp_type mrsp
);
   import alfl_pkg::*;

   logic [DATA_BITS-1:0] data_mem [NODES];
   logic [IDX_BITS-1:0]  link_mem [NODES];
   logic [IDX_BITS-1:0]  free_mem [NODES];

   always_ff @(posedge clock) begin
      if (mreq.wr_data) data_mem[mreq.wr_adr] <= mreq.data;
      if (mreq.wr_link) link_mem[mreq.wr_adr] <= mreq.link;
      if (mreq.wr_free) free_mem[mreq.wr_adr] <= mreq.link;
      if (mreq.rd) begin
         mrsp.data <= data_mem[mreq.rd_adr];
         mrsp.link <= link_mem[mreq.rd_adr];
         mrsp.free <= free_mem[mreq.rd_adr];
      end
   end
endmodule

[hdl/alfl_ctrl.sv]
// Sequencer that walks the list in the node store, one read per step.
// Depends on alfl_pkg; drives alfl_ram through a mem_req_type struct.
module alfl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  alfl_pkg::op_type      op,
   input  logic [alfl_pkg::DATA_BITS-1:0] din,
   input  logic [31:0]           key_mask,
   output logic                  idle,
   output logic                  done,
   input  logic                  taken,
   output logic [1:0]            status,
   output logic [alfl_pkg::IDX_BITS-1:0] found_index,
   output logic [alfl_pkg::IDX_BITS-1:0] current_index,
   output logic [alfl_pkg::DATA_BITS-1:0] current_data,
   output alfl_pkg::mem_req_type mreq,
   input  alfl_pkg::mem_rsp_type mrsp
);
   import alfl_pkg::*;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic [DATA_BITS-1:0] din_ff, din_in, cdata_ff, cdata_in;
   logic [IDX_BITS-1:0]  head_ff, head_in, cur_ff, cur_in, fhead_ff, fhead_in;
   logic [IDX_BITS-1:0]  hw_ff, hw_in, p_ff, p_in, pre_ff, pre_in, fnd_ff, fnd_in;
   logic [IDX_BITS-1:0]  steps_ff, steps_in;
   logic [1:0]           st_ff, st_in;
   // Set while the read in flight is the free list head (node allocation).
   logic                 alloc_ff, alloc_in;
   // Set while the second write of a request is still to be done.
   logic                 tail_ff, tail_in;
   logic [DATA_BITS-1:0] dmask;

   assign dmask = DATA_BITS'(key_mask);
   assign idle  = (state_ff == S_IDLE);
   assign done  = (state_ff == S_DONE);
   assign status = st_ff;
   assign found_index = fnd_ff;
   assign current_index = cur_ff;
   assign current_data = cdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= NONE;
         cur_ff   <= NONE;
         fhead_ff <= NONE;
         hw_ff    <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         cur_ff   <= cur_in;
         fhead_ff <= fhead_in;
         hw_ff    <= hw_in;
      end
      op_ff <= op_in; din_ff <= din_in; cdata_ff <= cdata_in;
      p_ff <= p_in; pre_ff <= pre_in; fnd_ff <= fnd_in;
      steps_ff <= steps_in; st_ff <= st_in; alloc_ff <= alloc_in;
      tail_ff <= tail_in;
   end

   always_comb begin
      logic [IDX_BITS-1:0] nn;
      logic full;
      full = (hw_ff >= NONE);
      nn = (fhead_ff != NONE) ? fhead_ff : hw_ff;
      state_in = state_ff; op_in = op_ff; din_in = din_ff; cdata_in = cdata_ff;
      head_in = head_ff; cur_in = cur_ff; fhead_in = fhead_ff; hw_in = hw_ff;
      p_in = p_ff; pre_in = pre_ff; fnd_in = fnd_ff; steps_in = steps_ff;
      st_in = st_ff; alloc_in = 1'b0; tail_in = tail_ff;
      mreq = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in = op; din_in = din; fnd_in = NONE; st_in = ST_OK;
               steps_in = '0; p_in = head_ff; pre_in = head_ff; tail_in = 1'b0;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_READCUR;
            if (tail_ff) begin
               // Second write: store the new rear node, or relink around a freed node.
               tail_in = 1'b0;
               mreq.wr_link = 1'b1;
               if (op_ff == OP_INS_REAR) begin
                  mreq.wr_data = 1'b1; mreq.wr_adr = ADR_BITS'(p_ff);
                  mreq.data = din_ff; mreq.link = NONE;
                  if (fhead_ff != NONE) begin
                     mreq.rd = 1'b1; mreq.rd_adr = ADR_BITS'(fhead_ff);
                     alloc_in = 1'b1; state_in = S_WAIT;
                  end else hw_in = hw_ff + 1'b1;
               end else begin
                  mreq.wr_adr = ADR_BITS'(pre_ff); mreq.link = p_ff;
               end
            end else begin
               case (op_ff)
                  OP_INS_FRONT, OP_INS_REAR: begin
                     if (op_ff == OP_INS_REAR && head_ff != NONE) begin
                        mreq.rd = 1'b1; mreq.rd_adr = ADR_BITS'(head_ff);
                        state_in = S_WAIT;
                     end else if (fhead_ff == NONE && full) begin
                        st_in = ST_FULL;
                     end else begin
                        mreq.wr_data = 1'b1; mreq.wr_link = 1'b1;
                        mreq.wr_adr = ADR_BITS'(nn); mreq.data = din_ff;
                        mreq.link = head_ff;
                        head_in = nn; cur_in = nn;
                        if (fhead_ff != NONE) begin
                           mreq.rd = 1'b1; mreq.rd_adr = ADR_BITS'(fhead_ff);
                           alloc_in = 1'b1; state_in = S_WAIT;
                        end else hw_in = hw_ff + 1'b1;
                     end
                  end
                  OP_RM_FRONT, OP_RM_REAR, OP_SEARCH, OP_CLEAR: begin
                     if (head_ff == NONE) begin
                        if (op_ff == OP_SEARCH) st_in = ST_NOTFOUND;
                        else if (op_ff != OP_CLEAR) st_in = ST_EMPTY;
                        else cur_in = NONE;
                     end else begin
                        mreq.rd = 1'b1; mreq.rd_adr = ADR_BITS'(head_ff);
                        state_in = S_WAIT;
                     end
                  end
                  OP_RM_CUR: begin
                     if (head_ff == NONE || cur_ff == NONE) st_in = ST_EMPTY;
                     else begin
                        mreq.rd = 1'b1; mreq.rd_adr = ADR_BITS'(head_ff);
                        state_in = S_WAIT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_WAIT: begin
            state_in = S_STEP;
            alloc_in = alloc_ff;
         end
         S_STEP: begin
            // mrsp holds data/link of node p_ff, or free link of the taken node.
            state_in = S_READCUR;
            if (alloc_ff) begin
               fhead_in = mrsp.free;
            end else begin
               case (op_ff)
                  OP_INS_REAR: begin
                     if (mrsp.link != NONE && steps_ff < IDX_BITS'(NODES)) begin
                        p_in = mrsp.link; steps_in = steps_ff + 1'b1;
                        mreq.rd = 1'b1; mreq.rd_adr = ADR_BITS'(mrsp.link);
                        state_in = S_WAIT;
                     end else if (fhead_ff == NONE && full) begin
                        st_in = ST_FULL;
                     end else begin
                        // Link rear to the new node here; write the new node next.
                        mreq.wr_link = 1'b1; mreq.wr_adr = ADR_BITS'(p_ff);
                        mreq.link = nn;
                        cur_in = nn; p_in = nn;
                        tail_in = 1'b1; state_in = S_DISPATCH;
                     end
                  end
                  OP_RM_FRONT: begin
                     mreq.wr_free = 1'b1; mreq.wr_adr = ADR_BITS'(head_ff);
                     mreq.link = fhead_ff; fhead_in = head_ff;
                     head_in = mrsp.link; cur_in = mrsp.link;
                  end
                  OP_CLEAR: begin
                     mreq.wr_free = 1'b1; mreq.wr_adr = ADR_BITS'(head_ff);
                     mreq.link = fhead_ff; fhead_in = head_ff;
                     head_in = mrsp.link;
                     if (mrsp.link != NONE && steps_ff < IDX_BITS'(NODES - 1)) begin
                        steps_in = steps_ff + 1'b1;
                        mreq.rd = 1'b1; mreq.rd_adr = ADR_BITS'(mrsp.link);
                        state_in = S_WAIT;
                     end else begin
                        head_in = NONE; cur_in = NONE;
                     end
                  end
                  OP_RM_REAR: begin
                     if (mrsp.link != NONE && steps_ff < IDX_BITS'(NODES)) begin
                        pre_in = p_ff; p_in = mrsp.link;
                        steps_in = steps_ff + 1'b1;
                        mreq.rd = 1'b1; mreq.rd_adr = ADR_BITS'(mrsp.link);
                        state_in = S_WAIT;
                     end else if (steps_ff == '0) begin
                        mreq.wr_free = 1'b1; mreq.wr_adr = ADR_BITS'(head_ff);
                        mreq.link = fhead_ff; fhead_in = head_ff;
                        head_in = mrsp.link; cur_in = mrsp.link;
                     end else begin
                        // The last node goes free; its predecessor becomes rear next.
                        mreq.wr_free = 1'b1; mreq.wr_adr = ADR_BITS'(p_ff);
                        mreq.link = fhead_ff;
                        fhead_in = p_ff; cur_in = pre_ff; p_in = NONE;
                        tail_in = 1'b1; state_in = S_DISPATCH;
                     end
                  end
                  OP_RM_CUR: begin
                     if (cur_ff == head_ff) begin
                        mreq.wr_free = 1'b1; mreq.wr_adr = ADR_BITS'(head_ff);
                        mreq.link = fhead_ff; fhead_in = head_ff;
                        head_in = mrsp.link; cur_in = mrsp.link;
                     end else if (p_ff == cur_ff) begin
                        // p_ff is the current node; its link closes the gap next.
                        mreq.wr_free = 1'b1; mreq.wr_adr = ADR_BITS'(p_ff);
                        mreq.link = fhead_ff;
                        fhead_in = p_ff; cur_in = pre_ff; p_in = mrsp.link;
                        tail_in = 1'b1; state_in = S_DISPATCH;
                     end else if (mrsp.link == cur_ff) begin
                        pre_in = p_ff; p_in = mrsp.link;
                        mreq.rd = 1'b1; mreq.rd_adr = ADR_BITS'(mrsp.link);
                        state_in = S_WAIT;
                     end else if (mrsp.link != NONE && steps_ff < IDX_BITS'(NODES)) begin
                        p_in = mrsp.link;
                        steps_in = steps_ff + 1'b1;
                        mreq.rd = 1'b1; mreq.rd_adr = ADR_BITS'(mrsp.link);
                        state_in = S_WAIT;
                     end else st_in = ST_EMPTY;
                  end
                  OP_SEARCH: begin
                     if ((mrsp.data & dmask) == (din_ff & dmask)) begin
                        cur_in = p_ff; fnd_in = p_ff;
                     end else if (mrsp.link != NONE
                                  && steps_ff < IDX_BITS'(NODES - 1)) begin
                        p_in = mrsp.link; steps_in = steps_ff + 1'b1;
                        mreq.rd = 1'b1; mreq.rd_adr = ADR_BITS'(mrsp.link);
                        state_in = S_WAIT;
                     end else st_in = ST_NOTFOUND;
                  end
                  default: ;
               endcase
            end
         end
         S_READCUR: begin
            if (cur_ff != NONE) begin
               mreq.rd = 1'b1; mreq.rd_adr = ADR_BITS'(cur_ff);
            end
            state_in = S_LOAD;
         end
         S_LOAD: begin
            cdata_in = (cur_ff != NONE) ? mrsp.data : '0;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (taken) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      done && !taken |=> done) else $error("result dropped before taken");
   a_hw_range: assert property (@(posedge clock) disable iff (reset)
      hw_ff <= NONE) else $error("high water beyond store");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> idle) else $error("request taken while busy");
`endif
endmodule

[test/array_linked_list_with_free_list_test.sv]
// Testbench for the array linked list with free list: a driver and a monitor
// around the block, with an in-bench list model that predicts every response.
// Depends on alfl_pkg and the top level array_linked_list_with_free_list.
`timescale 1ns / 100ps

module array_linked_list_with_free_list_test;
   import alfl_pkg::*;

   typedef struct packed {
      op_type      op;
      logic [31:0] data;
   } list_request;

   typedef struct packed {
      status_type  status;
      logic [8:0]  found;
      logic [8:0]  cur_idx;
      logic [31:0] cur_data;
   } list_response;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [55:0] rsp_tdata;
   logic        csr_we = 0;
   logic [31:0] csr_wdata = '0;

   array_linked_list_with_free_list dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // Model of the list contents.
   logic [31:0] m_data [NODES];
   logic [8:0]  m_link [NODES];
   logic [8:0]  m_free [NODES];
   logic [8:0]  m_head, m_cur, m_free_head;
   int          m_high;
   logic [31:0] m_mask;
   int          list_len;

   list_request  pending_requests[$];
   list_response expected_responses[$];
   int errors = 0;
   int checked = 0;
   int send_idle = 0;
   int recv_stall = 0;
   bit hold_req = 0;
   bit hold_off = 0;
   bit req_taken = 0;
   int status_seen[4];

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %0s: got %0h want %0h at %0t", what, got, want, $time);
      errors++;
   endtask

   function automatic logic [8:0] take_node();
      logic [8:0] n;
      if (m_free_head != NONE) begin
         n = m_free_head;
         m_free_head = m_free[n];
         return n;
      end
      if (m_high < NODES) begin
         n = m_high[8:0];
         m_high++;
         return n;
      end
      return NONE;
   endfunction

   function automatic void give_node(input logic [8:0] n);
      m_free[n] = m_free_head;
      m_free_head = n;
   endfunction

   function automatic status_type unlink_front();
      logic [8:0] nx;
      if (m_head == NONE) return ST_EMPTY;
      nx = m_link[m_head];
      give_node(m_head);
      m_head = nx;
      m_cur = nx;
      list_len--;
      return ST_OK;
   endfunction

   function automatic status_type link_front(input logic [31:0] x);
      logic [8:0] n;
      n = take_node();
      if (n == NONE) return ST_FULL;
      m_data[n] = x;
      m_link[n] = m_head;
      m_head = n;
      m_cur = n;
      list_len++;
      return ST_OK;
   endfunction

   function automatic list_response apply_request(input list_request r);
      list_response res;
      logic [8:0] p, pre, n;
      int steps;
      res.found = NONE;
      res.status = ST_OK;
      steps = 0;
      case (r.op)
         OP_INS_FRONT: res.status = link_front(r.data);
         OP_INS_REAR: begin
            if (m_head == NONE) res.status = link_front(r.data);
            else begin
               p = m_head;
               while (m_link[p] != NONE && steps < NODES) begin
                  p = m_link[p];
                  steps++;
               end
               n = take_node();
               if (n == NONE) res.status = ST_FULL;
               else begin
                  m_link[p] = n;
                  m_data[n] = r.data;
                  m_link[n] = NONE;
                  m_cur = n;
                  list_len++;
               end
            end
         end
         OP_RM_FRONT: res.status = unlink_front();
         OP_RM_REAR: begin
            if (m_head == NONE) res.status = ST_EMPTY;
            else if (m_link[m_head] == NONE) res.status = unlink_front();
            else begin
               p = m_head;
               pre = p;
               while (m_link[p] != NONE && steps < NODES) begin
                  pre = p;
                  p = m_link[p];
                  steps++;
               end
               m_link[pre] = NONE;
               give_node(p);
               m_cur = pre;
               list_len--;
            end
         end
         OP_RM_CUR: begin
            if (m_head == NONE || m_cur == NONE) res.status = ST_EMPTY;
            else if (m_cur == m_head) res.status = unlink_front();
            else begin
               p = m_head;
               while (p != NONE && m_link[p] != m_cur && steps < NODES) begin
                  p = m_link[p];
                  steps++;
               end
               if (p == NONE || m_link[p] != m_cur) res.status = ST_EMPTY;
               else begin
                  m_link[p] = m_link[m_cur];
                  give_node(m_cur);
                  m_cur = p;
                  list_len--;
               end
            end
         end
         OP_SEARCH: begin
            res.status = ST_NOTFOUND;
            p = m_head;
            while (p != NONE && steps < NODES) begin
               if ((m_data[p] & m_mask) == (r.data & m_mask)) begin
                  m_cur = p;
                  res.found = p;
                  res.status = ST_OK;
                  break;
               end
               p = m_link[p];
               steps++;
            end
         end
         OP_CLEAR: begin
            while (m_head != NONE && steps < NODES) begin
               void'(unlink_front());
               steps++;
            end
            m_head = NONE;
            m_cur = NONE;
            list_len = 0;
         end
         default: ;
      endcase
      res.cur_idx = m_cur;
      res.cur_data = (m_cur != NONE) ? m_data[m_cur] : '0;
      return res;
   endfunction

   // Driver: one request per handshake, random gaps between them.
   always @(negedge clock) begin
      if (reset) req_tvalid <= 0;
      else if (req_tvalid && !req_taken) ;
      else if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle) begin
         req_tvalid <= 1;
         req_tdata <= {5'b0, pending_requests[0].data, pending_requests[0].op};
      end else req_tvalid <= 0;
   end

   // The prediction is made when the request is accepted.
   always @(posedge clock) begin
      req_taken = !reset && req_tvalid && req_tready;
      if (req_taken) begin
         expected_responses.push_back(apply_request(pending_requests.pop_front()));
      end
   end

   always @(negedge clock) begin
      if (reset || hold_off) rsp_tready <= 0;
      else rsp_tready <= ($urandom_range(99) >= recv_stall);
   end

   // Receiver hold-off: once requested, it counts its own cycles.
   initial begin
      wait (hold_req);
      hold_off = 1;
      repeat (400) @(posedge clock);
      hold_off = 0;
   end

   // Monitor: compare each response with the oldest prediction.
   always @(posedge clock) begin
      list_response got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status   = status_type'(rsp_tdata[1:0]);
         got.found    = rsp_tdata[10:2];
         got.cur_idx  = rsp_tdata[19:11];
         got.cur_data = rsp_tdata[51:20];
         if (expected_responses.size() == 0) begin
            report_mismatch("unexpected response", rsp_tdata[51:20], 32'd0);
         end else begin
            want = expected_responses.pop_front();
            if (got.status !== want.status)
               report_mismatch("status", 32'(got.status), 32'(want.status));
            if (got.found !== want.found)
               report_mismatch("found_index", 32'(got.found), 32'(want.found));
            if (got.cur_idx !== want.cur_idx)
               report_mismatch("current_index", 32'(got.cur_idx), 32'(want.cur_idx));
            if (got.cur_data !== want.cur_data)
               report_mismatch("current_data", got.cur_data, want.cur_data);
            status_seen[want.status]++;
            checked++;
         end
      end
   end

   task automatic queue_request(input op_type op, input logic [31:0] x);
      list_request r;
      r.op = op;
      r.data = x;
      pending_requests.push_back(r);
   endtask

   task automatic wait_drained();
      while (pending_requests.size() > 0 || req_tvalid || expected_responses.size() > 0)
         @(posedge clock);
      repeat (3 * NODES + 20) @(posedge clock);
   endtask

   task automatic set_mask(input logic [31:0] mask);
      @(negedge clock);
      csr_we <= 1;
      csr_wdata <= mask;
      @(negedge clock);
      csr_we <= 0;
      m_mask = mask;
   endtask

   // Mostly well-formed traffic; list length is kept mostly small so walks stay short.
   task automatic queue_random(input int count, input int fill_bias);
      int k;
      logic [31:0] x;
      op_type op;
      for (k = 0; k < count; k++) begin
         x = $urandom();
         if ($urandom_range(3) == 0) x = x & 32'h0000_000F;
         case ($urandom_range(99) % 20)
            0, 1, 2: op = OP_INS_FRONT;
            3, 4, 5: op = OP_INS_REAR;
            6, 7: op = OP_RM_FRONT;
            8, 9: op = OP_RM_REAR;
            10, 11: op = OP_RM_CUR;
            12, 13, 14, 15: op = OP_SEARCH;
            16: op = ($urandom_range(9) == 0) ? OP_CLEAR : OP_NOP;
            default: op = ($urandom_range(99) < fill_bias) ? OP_INS_FRONT : OP_RM_FRONT;
         endcase
         queue_request(op, x);
      end
   endtask

   initial begin
      int i, phase;
      m_head = NONE; m_cur = NONE; m_free_head = NONE; m_high = 0;
      m_mask = '1; list_len = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: empty-list removals, misses, extremes and the unused op.
      queue_request(OP_RM_FRONT, 0);
      queue_request(OP_RM_REAR, 0);
      queue_request(OP_RM_CUR, 0);
      queue_request(OP_SEARCH, 32'hFFFF_FFFF);
      queue_request(OP_INS_FRONT, 32'hFFFF_FFFF);
      queue_request(OP_INS_REAR, 32'h0000_0000);
      queue_request(OP_INS_REAR, 32'hA5A5_5A5A);
      queue_request(OP_SEARCH, 32'h0000_0000);
      queue_request(OP_SEARCH, 32'h1234_5678);
      queue_request(OP_RM_CUR, 0);
      queue_request(OP_RM_REAR, 0);
      queue_request(OP_NOP, 32'hDEAD_BEEF);
      queue_request(OP_RM_FRONT, 0);
      queue_request(OP_RM_CUR, 0);
      queue_request(OP_CLEAR, 0);
      queue_request(OP_INS_FRONT, 32'h5A5A_A5A5);
      wait_drained();

      // Fill the store to the limit, then overflow both insert kinds.
      // The receiver holds off meanwhile so the block backs up.
      for (i = 0; i < NODES; i++) queue_request(OP_INS_FRONT, $urandom());
      hold_req = 1;
      wait (hold_off);
      wait (!hold_off);
      queue_request(OP_INS_FRONT, 32'h1);
      queue_request(OP_INS_REAR, 32'h2);
      queue_request(OP_SEARCH, 32'h3);
      queue_request(OP_RM_REAR, 0);
      queue_request(OP_CLEAR, 0);
      wait_drained();

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle = 0;  recv_stall = 0;  set_mask(32'h0000_0000); end
            1: begin send_idle = 65; recv_stall = 0;  set_mask(32'h0000_000F); end
            2: begin send_idle = 0;  recv_stall = 65; set_mask($urandom()); end
            default: begin send_idle = 14; recv_stall = 14; set_mask(32'hFFFF_FFFF); end
         endcase
         queue_random(300, phase == 2 ? 40 : 55);
         queue_request(OP_CLEAR, 0);
         wait_drained();
      end

      $display("Checked %0d responses: %0d ok, %0d empty, %0d not found, %0d full.",
               checked, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      $display("Covered directed corners, a full store, four key masks and four idle mixes.");
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #(64'd12 * 64'd10_000_000);
      $display("DONE: errors detected");
      $finish;
   end
endmodule
